// File: rtl/text_mode_console_writer_defines.svh
// Assertion macros for the text-mode console writer.
// The asserting module must have clk and arst_n in scope.
`ifndef TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
`define TMCW_ASSERT_IMPLY(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("tmcw: same-cycle check failed");
`define TMCW_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("tmcw: next-cycle check failed");
`else
`define TMCW_ASSERT_IMPLY(lbl, a, b)
`define TMCW_ASSERT_NEXT(lbl, a, b)
`endif

`endif

// File: rtl/tmcw_pkg.sv
`default_nettype none

package tmcw_pkg;

	localparam int FUNC_W    = 2;
	localparam int CHAR_W    = 8;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;
	localparam int POS_W     = 11;
	localparam int CELL_W    = 16;
	localparam int ATTR_W    = 8;
	// clamped coordinates, wide enough for the largest screen
	localparam int CMD_COL_W = 8;
	localparam int CMD_ROW_W = 6;

	localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SETCUR = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_CLEAR,
		OP_SETCUR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [CHAR_W-1:0]     char_code;
		logic [CMD_COL_W-1:0]  col;
		logic [CMD_ROW_W-1:0]  row;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_FILL,
		ST_BLANK
	} state_t;

endpackage

`default_nettype wire

// File: rtl/tmcw_ifs.sv
`default_nettype none

interface tmcw_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [tmcw_pkg::FUNC_W-1:0]   func;
	logic [tmcw_pkg::CHAR_W-1:0]   char_code;
	logic [tmcw_pkg::COL_W-1:0]    col;
	logic [tmcw_pkg::ROW_W-1:0]    row;

	modport source (output valid, func, char_code, col, row, input ready);
	modport sink (input valid, func, char_code, col, row, output ready);
endinterface

interface tmcw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tmcw_pkg::COL_W-1:0]    cursor_col;
	logic [tmcw_pkg::ROW_W-1:0]    cursor_row;
	logic [tmcw_pkg::POS_W-1:0]    cursor_pos;
	logic [tmcw_pkg::CELL_W-1:0]   cell_data;

	modport source (output valid, cursor_col, cursor_row, cursor_pos, cell_data, input ready);
	modport sink (input valid, cursor_col, cursor_row, cursor_pos, cell_data, output ready);
endinterface

interface tmcw_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tmcw_pkg::ATTR_W-1:0]   text_attr;

	modport source (output valid, text_attr, input ready);
	modport sink (input valid, text_attr, output ready);
endinterface

`default_nettype wire

// File: rtl/tmcw_ram.sv
`default_nettype none

module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/tmcw_front.sv
`default_nettype none

module tmcw_front #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     init_done,
	tmcw_cmd_if.sink      cmd,
	output logic          push_valid,
	input  wire logic     push_ready,
	output tmcw_pkg::cmd_t push_cmd
);
	import tmcw_pkg::*;

	logic     valid_s1;
	cmd_t     cmd_s1;
	cmd_t     cls;
	logic [CMD_COL_W-1:0] col_ext;
	logic [CMD_ROW_W-1:0] row_ext;

	// clamp coordinates to the screen and split newline from printable put
	always_comb begin
		col_ext = CMD_COL_W'(cmd.col);
		row_ext = CMD_ROW_W'(cmd.row);
		cls.char_code = cmd.char_code;
		cls.col = (col_ext > CMD_COL_W'(COLS - 1)) ? CMD_COL_W'(COLS - 1) : col_ext;
		cls.row = (row_ext > CMD_ROW_W'(ROWS - 1)) ? CMD_ROW_W'(ROWS - 1) : row_ext;
		unique case (cmd.func)
			FUNC_PUT: begin
				cls.op = (cmd.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
			end
			FUNC_CLEAR:  cls.op = OP_CLEAR;
			FUNC_SETCUR: cls.op = OP_SETCUR;
			FUNC_READ:   cls.op = OP_READ;
		endcase
	end

	assign cmd.ready  = init_done && (!valid_s1 || push_ready);
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || push_ready) begin
			valid_s1 <= cmd.valid && cmd.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cls;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tmcw_cmd_fifo.sv
`default_nettype none

module tmcw_cmd_fifo (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  tmcw_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  wire logic      pop_ready,
	output tmcw_pkg::cmd_t pop_cmd
);
	import tmcw_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != NW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tmcw_back.sv
`default_nettype none
`include "text_mode_console_writer_defines.svh"

module tmcw_back #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pop_valid,
	output logic                             pop_ready,
	input  tmcw_pkg::cmd_t                   pop_cmd,
	input  wire logic [tmcw_pkg::ATTR_W-1:0] text_attr,
	output logic                             init_done,
	tmcw_rsp_if.source                       rsp
);
	import tmcw_pkg::*;

	localparam int CW    = $clog2(COLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);

	state_t             state_q, state_d;
	logic [CW-1:0]      cur_col_q, col_d;
	logic [RW-1:0]      cur_row_q, row_d;
	// physical row that holds logical row 0; scrolling only moves this
	logic [RW-1:0]      top_q, top_d;
	logic [AW-1:0]      sweep_addr_q, sweep_last_q, sweep_start, sweep_end;
	logic               sweep_load, sweeping, sweep_done;
	logic               take, line_brk, scroll, col_last, row_last, load;
	logic               we;
	logic [AW-1:0]      waddr, raddr, pos_d;
	logic [CELL_W-1:0]  wdata, rdata;
	logic               rsp_valid_q;
	logic [COL_W-1:0]   rsp_col_q;
	logic [ROW_W-1:0]   rsp_row_q;
	logic [POS_W-1:0]   rsp_pos_q;
	logic [CELL_W-1:0]  rsp_data_q;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] top,
			input logic [RW-1:0] r, input logic [CW-1:0] c);
		logic [RW:0]   sum;
		logic [RW-1:0] pr;
		sum = {1'b0, top} + {1'b0, r};
		pr  = (sum >= (RW + 1)'(ROWS)) ? RW'(sum - (RW + 1)'(ROWS)) : RW'(sum);
		return AW'(AW'(pr) * AW'(COLS) + AW'(c));
	endfunction

	tmcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sweeping   = (state_q == ST_INIT) || (state_q == ST_FILL) || (state_q == ST_BLANK);
	assign sweep_done = (sweep_addr_q == sweep_last_q);
	assign init_done  = (state_q != ST_INIT);
	assign pop_ready  = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign take       = pop_valid && pop_ready;
	assign load       = (take && (pop_cmd.op != OP_READ)) || (state_q == ST_READ);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT, ST_FILL, ST_BLANK: begin
				if (sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_IDLE: begin
				if (take) begin
					case (pop_cmd.op)
						OP_CLEAR: state_d = ST_FILL;
						OP_READ:  state_d = ST_READ;
						OP_PUT, OP_NEWLINE: begin
							if (scroll) begin
								state_d = ST_BLANK;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// cursor, memory port and sweep control
	always_comb begin
		col_last    = (cur_col_q == CW'(COLS - 1));
		row_last    = (cur_row_q == RW'(ROWS - 1));
		line_brk    = 1'b0;
		col_d       = cur_col_q;
		row_d       = cur_row_q;
		top_d       = top_q;
		we          = sweeping;
		waddr       = sweep_addr_q;
		wdata       = (state_q == ST_INIT) ? {RESET_ATTR, SPACE_CODE} : {text_attr, SPACE_CODE};
		raddr       = cell_addr(top_q, RW'(pop_cmd.row), CW'(pop_cmd.col));
		sweep_load  = 1'b0;
		sweep_start = '0;
		sweep_end   = AW'(CELLS - 1);
		if (take) begin
			case (pop_cmd.op)
				OP_PUT: begin
					we    = 1'b1;
					waddr = cell_addr(top_q, cur_row_q, cur_col_q);
					wdata = {text_attr, pop_cmd.char_code};
					if (col_last) begin
						line_brk = 1'b1;
					end else begin
						col_d = cur_col_q + 1'b1;
					end
				end
				OP_NEWLINE: line_brk = 1'b1;
				OP_CLEAR: begin
					col_d      = '0;
					row_d      = '0;
					top_d      = '0;
					sweep_load = 1'b1;
				end
				OP_SETCUR: begin
					col_d = CW'(pop_cmd.col);
					row_d = RW'(pop_cmd.row);
				end
				default: ;
			endcase
		end
		scroll = line_brk && row_last;
		if (line_brk) begin
			col_d = '0;
			if (!row_last) begin
				row_d = cur_row_q + 1'b1;
			end
		end
		// old top row leaves the screen and comes back as the blank bottom row
		if (scroll) begin
			top_d       = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
			sweep_load  = 1'b1;
			sweep_start = AW'(AW'(top_q) * AW'(COLS));
			sweep_end   = sweep_start + AW'(COLS - 1);
		end
		pos_d = AW'(AW'(row_d) * AW'(COLS) + AW'(col_d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			top_q        <= '0;
			sweep_addr_q <= '0;
			sweep_last_q <= AW'(CELLS - 1);
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_col_q <= col_d;
			cur_row_q <= row_d;
			top_q     <= top_d;
			if (sweep_load) begin
				sweep_addr_q <= sweep_start;
				sweep_last_q <= sweep_end;
			end else if (sweeping) begin
				sweep_addr_q <= sweep_addr_q + 1'b1;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_col_q  <= COL_W'(col_d);
			rsp_row_q  <= ROW_W'(row_d);
			rsp_pos_q  <= POS_W'(pos_d);
			rsp_data_q <= (state_q == ST_READ) ? rdata : '0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cursor_col = rsp_col_q;
	assign rsp.cursor_row = rsp_row_q;
	assign rsp.cursor_pos = rsp_pos_q;
	assign rsp.cell_data  = rsp_data_q;

	`TMCW_ASSERT_IMPLY(a_cursor_on_screen, 1'b1, (cur_row_q <= RW'(ROWS - 1)) && (cur_col_q <= CW'(COLS - 1)))
	`TMCW_ASSERT_IMPLY(a_top_on_screen, 1'b1, top_q <= RW'(ROWS - 1))
	`TMCW_ASSERT_IMPLY(a_read_slot_free, state_q == ST_READ, !rsp_valid_q)
	`TMCW_ASSERT_NEXT(a_scroll_blanks_row, take && scroll, (state_q == ST_BLANK) && (cur_row_q == RW'(ROWS - 1)))
	`TMCW_ASSERT_IMPLY(a_sweep_in_bounds, sweeping, sweep_addr_q <= sweep_last_q)

endmodule

`default_nettype wire

// File: rtl/text_mode_console_writer.sv
`default_nettype none
// A word passes the front-end register, the command FIFO and the back end's response register;
// a read also passes ST_READ for the registered RAM read. Throughput: one word per cycle for
// put and set cursor while responses are taken, set by the single-write cell RAM port.
// A scroll holds the next word while the bottom row is blanked, a clear while all cells are
// blanked. Reset: asynchronous, active low; a pass then blanks the RAM, no word taken.

module text_mode_console_writer #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tmcw_cmd_if.sink   cmd,
	tmcw_rsp_if.source rsp,
	tmcw_cfg_if.sink   cfg
);
	import tmcw_pkg::*;

	logic [ATTR_W-1:0] text_attr_q;
	logic              init_done;
	logic              push_valid, push_ready;
	cmd_t              push_cmd;
	logic              pop_valid, pop_ready;
	cmd_t              pop_cmd;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= RESET_ATTR;
		end else if (cfg.valid && cfg.ready) begin
			text_attr_q <= cfg.text_attr;
		end
	end

	tmcw_front #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.init_done  (init_done),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	tmcw_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	tmcw_back #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.text_attr (text_attr_q),
		.init_done (init_done),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// File: verif/tb_text_mode_console_writer.sv
`timescale 1ns / 1ps

module tb_text_mode_console_writer;
	import tmcw_pkg::*;

	localparam int COLS           = 80;
	localparam int ROWS           = 25;
	localparam int SCREEN_CELLS   = COLS * ROWS;
	// a clear keeps rewriting cells after its word has come back
	localparam int SETTLE_CYCLES  = SCREEN_CELLS + 64;
	localparam int TAIL_CYCLES    = 100;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_WORDS    = 110;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [CHAR_W-1:0] char_code;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} console_cmd_t;

	typedef struct {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [POS_W-1:0]  cursor_pos;
		logic [CELL_W-1:0] cell_data;
	} cursor_report_t;

	logic clk = 1'b0;
	logic arst_n;

	tmcw_cmd_if cmd ();
	tmcw_rsp_if rsp ();
	tmcw_cfg_if cfg ();

	text_mode_console_writer #(
		.COLS(COLS),
		.ROWS(ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rsp(rsp),
		.cfg(cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the console
	logic [CELL_W-1:0] shadow_cells [SCREEN_CELLS];
	logic [COL_W-1:0]  shadow_col;
	logic [ROW_W-1:0]  shadow_row;
	logic [ATTR_W-1:0] attr_shadow;

	console_cmd_t   console_cmds[$];
	cursor_report_t awaited_reports[$];
	console_cmd_t   issued_cmd;
	int             cmds_accepted;
	int             reports_checked;
	int             stall_cycles;
	int             errors;

	function automatic void fill_screen(input logic [ATTR_W-1:0] attr);
		int i;
		for (i = 0; i < SCREEN_CELLS; i++)
			shadow_cells[i] = {attr, SPACE_CODE};
	endfunction

	function automatic void advance_row();
		int i;
		shadow_col = '0;
		if (shadow_row == ROWS - 1) begin
			for (i = 0; i < COLS * (ROWS - 1); i++)
				shadow_cells[i] = shadow_cells[i + COLS];
			for (i = COLS * (ROWS - 1); i < SCREEN_CELLS; i++)
				shadow_cells[i] = {attr_shadow, SPACE_CODE};
		end else begin
			shadow_row = shadow_row + 1'b1;
		end
	endfunction

	function automatic cursor_report_t next_cursor_report(input console_cmd_t c);
		cursor_report_t rep;
		int unsigned    cc;
		int unsigned    rr;
		cc = (c.col > COLS - 1) ? COLS - 1 : c.col;
		rr = (c.row > ROWS - 1) ? ROWS - 1 : c.row;
		rep.cell_data = '0;
		case (c.func)
			FUNC_PUT: begin
				if (c.char_code == NEWLINE_CODE) begin
					advance_row();
				end else begin
					shadow_cells[shadow_row * COLS + shadow_col] = {attr_shadow, c.char_code};
					if (shadow_col == COLS - 1)
						advance_row();
					else
						shadow_col = shadow_col + 1'b1;
				end
			end
			FUNC_CLEAR: begin
				fill_screen(attr_shadow);
				shadow_col = '0;
				shadow_row = '0;
			end
			FUNC_SETCUR: begin
				shadow_col = COL_W'(cc);
				shadow_row = ROW_W'(rr);
			end
			default: rep.cell_data = shadow_cells[rr * COLS + cc];
		endcase
		rep.cursor_col = shadow_col;
		rep.cursor_row = shadow_row;
		rep.cursor_pos = POS_W'(shadow_row * COLS + shadow_col);
		return rep;
	endfunction

	function automatic console_cmd_t random_console_cmd();
		console_cmd_t c;
		int unsigned  pick;
		pick = $urandom_range(99);
		c.char_code = CHAR_W'($urandom_range(255));
		c.col = COL_W'($urandom_range(127));
		c.row = ROW_W'($urandom_range(31));
		if (pick < 55) begin
			c.func = FUNC_PUT;
			if ($urandom_range(99) < 15)
				c.char_code = NEWLINE_CODE;
		end else if (pick < 71) begin
			c.func = FUNC_SETCUR;
			// mostly land on screen, often near the bottom so lines scroll
			if ($urandom_range(3) != 0) begin
				c.col = COL_W'($urandom_range(COLS - 1));
				if ($urandom_range(1) != 0)
					c.row = ROW_W'($urandom_range(ROWS - 1, ROWS - 5));
				else
					c.row = ROW_W'($urandom_range(ROWS - 1));
			end
		end else if (pick < 98) begin
			c.func = FUNC_READ;
			if ($urandom_range(9) < 6) begin
				c.col = COL_W'($urandom_range(COLS - 1));
				c.row = ROW_W'($urandom_range(ROWS - 1, ROWS - 10));
			end
		end else begin
			c.func = FUNC_CLEAR;
		end
		return c;
	endfunction

	task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
		console_cmd_t c;
		c.func = func;
		c.char_code = ch;
		c.col = col;
		c.row = row;
		console_cmds.push_back(c);
	endtask

	task automatic wait_drained(input int extra_cycles);
		do
			@(negedge clk);
		while (console_cmds.size() != 0 || cmd.valid || awaited_reports.size() != 0);
		repeat (extra_cycles) @(negedge clk);
	endtask

	task automatic write_text_attr(input logic [ATTR_W-1:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.text_attr <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		attr_shadow = value;
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// command driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				awaited_reports.push_back(next_cursor_report(issued_cmd));
				cmds_accepted <= cmds_accepted + 1;
			end
			if (!cmd.valid || cmd.ready) begin
				if (console_cmds.size() != 0 && ($urandom_range(99) >= 10
						|| (cmds_accepted >= 300 && cmds_accepted < 420))) begin
					issued_cmd = console_cmds.pop_front();
					cmd.valid <= 1'b1;
					cmd.func <= issued_cmd.func;
					cmd.char_code <= issued_cmd.char_code;
					cmd.col <= issued_cmd.col;
					cmd.row <= issued_cmd.row;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// report monitor and watchdog
	always @(posedge clk) begin
		cursor_report_t want;
		if (arst_n) begin
			rsp.ready <= $urandom_range(99) >= 10
				|| (reports_checked >= 300 && reports_checked < 420);
			if (rsp.valid && rsp.ready) begin
				reports_checked <= reports_checked + 1;
				if (awaited_reports.size() == 0) begin
					errors++;
					$display("%0t: report with none awaited, expected nothing, actual col %0d row %0d pos %0d cell %h",
						$time, rsp.cursor_col, rsp.cursor_row, rsp.cursor_pos, rsp.cell_data);
				end else begin
					want = awaited_reports.pop_front();
					check_field("cursor_col", want.cursor_col, rsp.cursor_col);
					check_field("cursor_row", want.cursor_row, rsp.cursor_row);
					check_field("cursor_pos", want.cursor_pos, rsp.cursor_pos);
					check_field("cell_data", want.cell_data, rsp.cell_data);
				end
			end
		end
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, stall_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [ATTR_W-1:0] next_attr;
		int phase;
		int i;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.func = FUNC_PUT;
		cmd.char_code = '0;
		cmd.col = '0;
		cmd.row = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.text_attr = RESET_ATTR;
		attr_shadow = RESET_ATTR;
		fill_screen(RESET_ATTR);
		shadow_col = '0;
		shadow_row = '0;
		cmds_accepted = 0;
		reports_checked = 0;
		stall_cycles = 0;
		errors = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// blank screen after reset, then clamped read of the far corner
		queue_cmd(FUNC_READ, 8'h00, 7'd0, 5'd0);
		queue_cmd(FUNC_READ, 8'hFF, 7'd127, 5'd31);
		queue_cmd(FUNC_PUT, 8'h41, 7'd0, 5'd0);
		queue_cmd(FUNC_PUT, 8'hFF, 7'd127, 5'd31);
		queue_cmd(FUNC_PUT, 8'h00, 7'd0, 5'd0);
		queue_cmd(FUNC_READ, 8'h00, 7'd0, 5'd0);
		queue_cmd(FUNC_READ, 8'h00, 7'd1, 5'd0);
		queue_cmd(FUNC_READ, 8'h00, 7'd2, 5'd0);
		queue_cmd(FUNC_PUT, NEWLINE_CODE, 7'd0, 5'd0);
		// a put at the last column of the last row wraps and scrolls
		queue_cmd(FUNC_SETCUR, 8'h00, 7'd127, 5'd31);
		queue_cmd(FUNC_PUT, 8'h80, 7'd0, 5'd0);
		queue_cmd(FUNC_READ, 8'h00, 7'd79, 5'd23);
		queue_cmd(FUNC_READ, 8'h00, 7'd0, 5'd24);
		// newline on the last row scrolls too
		queue_cmd(FUNC_SETCUR, 8'h00, 7'd0, 5'd24);
		queue_cmd(FUNC_PUT, NEWLINE_CODE, 7'd0, 5'd0);
		queue_cmd(FUNC_READ, 8'h00, 7'd79, 5'd22);
		queue_cmd(FUNC_SETCUR, 8'hFF, 7'd79, 5'd0);
		queue_cmd(FUNC_PUT, 8'h7F, 7'd0, 5'd0);
		queue_cmd(FUNC_SETCUR, 8'h00, 7'd80, 5'd25);
		queue_cmd(FUNC_READ, 8'h00, 7'd80, 5'd25);
		queue_cmd(FUNC_CLEAR, 8'hFF, 7'd127, 5'd31);
		queue_cmd(FUNC_READ, 8'h00, 7'd5, 5'd5);
		queue_cmd(FUNC_SETCUR, 8'h00, 7'd0, 5'd0);
		for (i = 0; i < 100; i++)
			console_cmds.push_back(random_console_cmd());
		wait_drained(SETTLE_CYCLES);

		for (phase = 0; phase < 5; phase++) begin
			next_attr = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF
				: ATTR_W'($urandom_range(255));
			write_text_attr(next_attr);
			for (i = 0; i < PHASE_WORDS; i++) begin
				if (i == PHASE_WORDS / 2)
					queue_cmd(FUNC_CLEAR, CHAR_W'($urandom_range(255)), 7'd0, 5'd0);
				console_cmds.push_back(random_console_cmd());
			end
			wait_drained(phase == 4 ? TAIL_CYCLES : SETTLE_CYCLES);
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
